### src/sms_notice_parser_defines.svh
// Assertion macros used by the SMS notice parser controller
`ifndef SMS_NOTICE_PARSER_DEFINES_SVH
`define SMS_NOTICE_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SNP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SNP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/snp_pkg.sv
// Types, constants and helpers for the SMS notice parser
`timescale 1ns / 1ps

package snp_pkg;

    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 4;
    localparam int POS_W        = 5;
    localparam int MSG_W        = 7;
    localparam int OUT_TDATA_W  = 16;
    localparam int RESULT_COUNT = 10;
    localparam int KEY_LEN      = 5;

    localparam int DEF_PHONE_LEN  = 13;
    localparam int DEF_PREFIX_LEN = 3;
    localparam int DEF_MSG_MAX    = 100;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_NUMBER,
        ST_SKIP,
        ST_TEXT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             store_wr;
        logic             msg_step;
        logic             msg_close;
        logic             out_load;
        logic             out_last;
        logic [IDX_W-1:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic is_quote;
        logic is_lf;
        logic out_free;
    } t_stat;

    function automatic logic [BYTE_W-1:0] keyword_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h74;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h63;
            3'd4:    ch = 8'h6B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### src/sms_notice_parser.sv
// The closing line feed moves the controller into ST_EMIT, which loads the first result
// into the output register once it is free. Throughput: one byte per cycle while parsing;
// ST_EMIT blocks input while ten results load, one per cycle while the output is free.
// The final result may wait in the output register while the next byte is taken.
// Reset: synchronous active low; clears phase, counters and output valid, not the number store.
`timescale 1ns / 1ps

module sms_notice_parser #(
    parameter int PHONE_LEN  = snp_pkg::DEF_PHONE_LEN,
    parameter int PREFIX_LEN = snp_pkg::DEF_PREFIX_LEN,
    parameter int MSG_MAX    = snp_pkg::DEF_MSG_MAX
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [snp_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [snp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [7:0] phone_char, [11:8] char_index
    output logic [0:0]                       m_axis_tuser,  // [0] is_track
    output logic                             m_axis_tlast
);
    import snp_pkg::*;

    localparam int AW = $clog2(PHONE_LEN);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [AW-1:0] w_store_idx;
    logic          w_track;

    snp_ctrl #(
        .PHONE_LEN (PHONE_LEN),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_store_idx (w_store_idx)
    );

    snp_datapath #(
        .PHONE_LEN  (PHONE_LEN),
        .PREFIX_LEN (PREFIX_LEN),
        .MSG_MAX    (MSG_MAX),
        .AW         (AW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (s_axis_tdata),
        .i_store_idx (w_store_idx),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_track (w_track),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = w_track;

endmodule

### src/snp_datapath.sv
// Datapath: number store, message checks and result register
`timescale 1ns / 1ps

module snp_datapath #(
    parameter int PHONE_LEN  = snp_pkg::DEF_PHONE_LEN,
    parameter int PREFIX_LEN = snp_pkg::DEF_PREFIX_LEN,
    parameter int MSG_MAX    = snp_pkg::DEF_MSG_MAX,
    parameter int AW         = $clog2(PHONE_LEN)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [snp_pkg::BYTE_W-1:0]       i_byte,
    input  logic [AW-1:0]                    i_store_idx,
    input  snp_pkg::t_cmd                    i_cmd,
    output snp_pkg::t_stat                   o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [snp_pkg::OUT_TDATA_W-1:0]  o_out_data,
    output logic                             o_out_track,
    output logic                             o_out_last
);
    import snp_pkg::*;

    logic [BYTE_W-1:0] r_store [PHONE_LEN];
    logic [MSG_W-1:0]  r_msg_cnt;
    logic              r_key_ok;
    logic              r_match;
    logic              r_valid;
    logic [BYTE_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic              r_track;
    logic              r_last;

    logic [POS_W-1:0]  n_pos;
    logic              n_key_miss;

    assign n_pos      = POS_W'(PREFIX_LEN) + POS_W'(i_cmd.emit_idx);
    assign n_key_miss = (r_msg_cnt < MSG_W'(KEY_LEN)) &&
                        (i_byte != keyword_char(r_msg_cnt[2:0]));

    assign o_stat.is_quote = (i_byte == CH_QUOTE);
    assign o_stat.is_lf    = (i_byte == CH_LF);
    assign o_stat.out_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_store[i_store_idx] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_cnt <= '0;
            r_key_ok  <= 1'b1;
            r_match   <= 1'b0;
        end else if (i_cmd.msg_close) begin
            r_match   <= r_key_ok && (r_msg_cnt == MSG_W'(KEY_LEN + 1));
            r_msg_cnt <= '0;
            r_key_ok  <= 1'b1;
        end else if (i_cmd.msg_step) begin
            if (n_key_miss) begin
                r_key_ok <= 1'b0;
            end
            if (r_msg_cnt < MSG_W'(MSG_MAX)) begin
                r_msg_cnt <= r_msg_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_char  <= (n_pos < POS_W'(PHONE_LEN)) ? r_store[n_pos[AW-1:0]] : '0;
            r_idx   <= i_cmd.emit_idx;
            r_track <= r_match;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = {{(OUT_TDATA_W - BYTE_W - IDX_W){1'b0}}, r_idx, r_char};
    assign o_out_track = r_track;
    assign o_out_last  = r_last;

endmodule

### src/snp_ctrl.sv
// Controller: parse phase state machine, store address and result sequencing
`timescale 1ns / 1ps
`include "sms_notice_parser_defines.svh"

module snp_ctrl #(
    parameter int PHONE_LEN = snp_pkg::DEF_PHONE_LEN,
    parameter int AW        = $clog2(PHONE_LEN)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  snp_pkg::t_stat i_stat,
    output snp_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]  o_store_idx
);
    import snp_pkg::*;

    t_state           r_state,     n_state;
    logic [AW-1:0]    r_phone_idx, n_phone_idx;
    logic [IDX_W-1:0] r_emit_idx,  n_emit_idx;
    logic             n_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_phone_idx <= '0;
            r_emit_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_phone_idx <= n_phone_idx;
            r_emit_idx  <= n_emit_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phone_idx = r_phone_idx;
        n_emit_idx  = r_emit_idx;
        o_in_ready  = (r_state != ST_EMIT);
        n_accept    = i_in_valid && o_in_ready;
        o_cmd       = '0;
        o_cmd.emit_idx = r_emit_idx;
        case (r_state)
            ST_WAIT: begin
                if (n_accept && i_stat.is_quote) begin
                    n_state = ST_NUMBER;
                end
            end
            ST_NUMBER: begin
                if (n_accept) begin
                    o_cmd.store_wr = 1'b1;
                    if (r_phone_idx == AW'(PHONE_LEN - 1)) begin
                        n_phone_idx = '0;
                        n_state     = ST_SKIP;
                    end else begin
                        n_phone_idx = r_phone_idx + 1'b1;
                    end
                end
            end
            ST_SKIP: begin
                if (n_accept && i_stat.is_lf) begin
                    n_state = ST_TEXT;
                end
            end
            ST_TEXT: begin
                if (n_accept) begin
                    if (i_stat.is_lf) begin
                        o_cmd.msg_close = 1'b1;
                        n_emit_idx      = '0;
                        n_state         = ST_EMIT;
                    end else begin
                        o_cmd.msg_step = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_emit_idx == IDX_W'(RESULT_COUNT - 1)) begin
                        o_cmd.out_last = 1'b1;
                        n_emit_idx     = '0;
                        n_state        = ST_WAIT;
                    end else begin
                        n_emit_idx = r_emit_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    assign o_store_idx = r_phone_idx;

    `SNP_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, o_cmd.out_load && o_cmd.out_last, r_state == ST_WAIT, "final result did not return to quote wait")
    `SNP_ASSERT_IMP(a_store_idx_range, i_clk, i_rst_n, 1'b1, r_phone_idx <= AW'(PHONE_LEN - 1), "number store index out of range")
    `SNP_ASSERT_NXT(a_close_starts_emit, i_clk, i_rst_n, (r_state == ST_TEXT) && n_accept && i_stat.is_lf, (r_state == ST_EMIT) && (r_emit_idx == '0), "closing line feed did not start result run")

endmodule
